// ----- hdl/fwrr_pkg.sv -----
package fwrr_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_APPEND       = 2'd0,
        CMD_REMOVE_FRONT = 2'd1,
        CMD_REMOVE_REAR  = 2'd2,
        CMD_CLEAR        = 2'd3
    } cmd_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LENGTH_W = 5;

    // Command word
    typedef struct packed {
        cmd_t                     cmd;
        logic signed [WORD_W-1:0] value;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [WORD_W-1:0]   removed_value;
        status_t                    status;
        logic        [LENGTH_W-1:0] length;
        logic signed [WORD_W-1:0]   front_value;
        logic signed [WORD_W-1:0]   rear_value;
    } out_word_t;

    // Per-step moves broadcast to every cell, already qualified
    typedef struct packed {
        logic push;
        logic pop_front;
        logic pop_rear;
        logic clear;
    } cell_ctl_t;

endpackage

// ----- hdl/fwrr_cell.sv -----
// One slot of the queue. The front chain packs entries from cell 0 (oldest
// first); the rear chain packs them from cell 0 (newest first). Both hold the
// same contents, so either end of the queue is always at cell 0.
module fwrr_cell #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fwrr_pkg::cell_ctl_t     ctl,
    input  logic [DATA_WIDTH-1:0]   push_data,
    input  logic [DATA_WIDTH-1:0]   front_upper,
    input  logic [DATA_WIDTH-1:0]   rear_lower,
    input  logic [DATA_WIDTH-1:0]   rear_upper,
    input  logic                    occ_lower,
    input  logic                    occ_upper,
    output logic [DATA_WIDTH-1:0]   front_q,
    output logic [DATA_WIDTH-1:0]   rear_q,
    output logic                    occ_q
);

    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] front_next;
    logic [DATA_WIDTH-1:0] rear_reg;
    logic [DATA_WIDTH-1:0] rear_next;
    logic                  occ_reg;
    logic                  occ_next;

    // Front chain: fill the first free slot, shift down on front removal
    always_comb
    begin
        front_next = front_reg;
        if (ctl.push && !occ_reg && occ_lower)
        begin
            front_next = push_data;
        end
        else if (ctl.pop_front)
        begin
            front_next = front_upper;
        end
    end

    // Rear chain: shift up on append, shift down on rear removal
    always_comb
    begin
        rear_next = rear_reg;
        if (ctl.push)
        begin
            rear_next = rear_lower;
        end
        else if (ctl.pop_rear)
        begin
            rear_next = rear_upper;
        end
    end

    // Occupancy thermometer
    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctl.push)
        begin
            occ_next = occ_lower;
        end
        else if (ctl.pop_front || ctl.pop_rear)
        begin
            occ_next = occ_upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Data needs no reset
    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
    end

    assign front_q = front_reg;
    assign rear_q  = rear_reg;
    assign occ_q   = occ_reg;

endmodule

// ----- hdl/fifo_with_rear_removal.sv -----
// Bounded queue of DEPTH signed words with append at the rear, removal from
// either end, and clear. One command word is taken per cycle and each gives one
// result word showing the removed word, a status, and the length and both end
// words after the command; the result appears the cycle after the command is
// taken and is held until taken. A command is refused only while a result still
// waits, so with the output ready the block runs at one command every cycle.
// Storage is a row of DEPTH identical cells holding two mirrored chains, so
// the front and rear words are always read at cell 0 and no wide selection is
// needed. Words are stored in DATA_WIDTH bits and read back sign-extended.
module fifo_with_rear_removal #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fwrr_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fwrr_pkg::out_word_t out_data
);

    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    logic                       in_accept;
    logic                       full;
    logic                       empty;
    fwrr_pkg::cell_ctl_t        ctl;
    logic [DATA_WIDTH-1:0]      push_data;
    logic [DATA_WIDTH-1:0]      front_q [DEPTH];
    logic [DATA_WIDTH-1:0]      rear_q  [DEPTH];
    logic [DEPTH-1:0]           occ;
    logic [DATA_WIDTH-1:0]      front_link [DEPTH];
    logic [DATA_WIDTH-1:0]      rear_link  [DEPTH+2];
    logic [DEPTH+1:0]           occ_link;

    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [fwrr_pkg::WORD_W-1:0] removed_reg;
    logic [fwrr_pkg::WORD_W-1:0] removed_next;
    fwrr_pkg::status_t          status_reg;
    fwrr_pkg::status_t          status_next;

    // Handshake: a new word only when the result slot is free or emptying
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign full      = occ[DEPTH-1];
    assign empty     = !occ[0];
    assign push_data = DATA_WIDTH'($unsigned(in_data.value));

    // Qualified moves
    always_comb
    begin
        ctl = '0;
        if (in_accept)
        begin
            case (in_data.cmd)
                fwrr_pkg::CMD_APPEND:       ctl.push      = !full;
                fwrr_pkg::CMD_REMOVE_FRONT: ctl.pop_front = !empty;
                fwrr_pkg::CMD_REMOVE_REAR:  ctl.pop_rear  = !empty;
                fwrr_pkg::CMD_CLEAR:        ctl.clear     = 1'b1;
                default:                    ctl           = '0;
            endcase
        end
    end

    // Neighbour links, with fixed values past either end of the row;
    // front_link[i] is the front word just above cell i
    assign front_link[DEPTH-1] = '0;
    assign rear_link[0]        = push_data;
    assign rear_link[DEPTH+1]  = '0;
    assign occ_link[0]         = 1'b1;
    assign occ_link[DEPTH+1]   = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i + 1 < DEPTH)
        begin : g_front
            assign front_link[i] = front_q[i+1];
        end
        assign rear_link[i+1] = rear_q[i];
        assign occ_link[i+1]  = occ[i];

        fwrr_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .push_data   (push_data),
            .front_upper (front_link[i]),
            .rear_lower  (rear_link[i]),
            .rear_upper  (rear_link[i+2]),
            .occ_lower   (occ_link[i]),
            .occ_upper   (occ_link[i+2]),
            .front_q     (front_q[i]),
            .rear_q      (rear_q[i]),
            .occ_q       (occ[i])
        );
    end

    // Length, removed word, status and result valid
    always_comb
    begin
        count_next     = count_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            out_valid_next = 1'b1;
            removed_next   = '0;
            status_next    = fwrr_pkg::ST_DONE;
            case (in_data.cmd)
                fwrr_pkg::CMD_APPEND:
                begin
                    if (full)
                    begin
                        status_next = fwrr_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                fwrr_pkg::CMD_REMOVE_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = fwrr_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        removed_next = fwrr_pkg::WORD_W'($signed(front_q[0]));
                        count_next   = count_reg - COUNT_W'(1);
                    end
                end
                fwrr_pkg::CMD_REMOVE_REAR:
                begin
                    if (empty)
                    begin
                        status_next = fwrr_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        removed_next = fwrr_pkg::WORD_W'($signed(rear_q[0]));
                        count_next   = count_reg - COUNT_W'(1);
                    end
                end
                fwrr_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= fwrr_pkg::ST_DONE;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
    end

    // Result word: end words come straight from cell 0 of each chain
    assign out_valid              = out_valid_reg;
    assign out_data.removed_value = removed_reg;
    assign out_data.status        = status_reg;
    assign out_data.length        = fwrr_pkg::LENGTH_W'(count_reg);
    assign out_data.front_value   = empty ? '0 : fwrr_pkg::WORD_W'($signed(front_q[0]));
    assign out_data.rear_value    = empty ? '0 : fwrr_pkg::WORD_W'($signed(rear_q[0]));

`ifndef SYNTHESIS
    // Occupancy thermometer agrees with the length
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ) == 32'(count_reg))
        else $error("occupancy does not match length");

    // Occupancy is packed from cell 0
    a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ + DEPTH'(1)) & occ) == '0)
        else $error("occupancy not contiguous");

    // Append to a queue with room grows it by one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_data.cmd == fwrr_pkg::CMD_APPEND && !full
        |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("append did not grow queue");

    // Removal from an empty queue reports empty
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && empty
        && (in_data.cmd == fwrr_pkg::CMD_REMOVE_FRONT
            || in_data.cmd == fwrr_pkg::CMD_REMOVE_REAR)
        |=> status_reg == fwrr_pkg::ST_EMPTY && removed_reg == '0)
        else $error("empty removal not reported");
`endif

endmodule

// ----- test/fifo_with_rear_removal_test.sv -----
`timescale 1ns / 1ps

module fifo_with_rear_removal_test;

    localparam int unsigned QUEUE_DEPTH  = 16;
    localparam int unsigned RANDOM_WORDS = 600;
    localparam int unsigned LONG_HOLD    = 100;
    localparam int unsigned SETTLE_TIME  = 10;

    // Command word waiting to be driven; drain_first holds it back until
    // every outstanding result has been taken
    typedef struct {
        fwrr_pkg::in_word_t word;
        bit                 drain_first;
    } pending_word_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    fwrr_pkg::in_word_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    fwrr_pkg::out_word_t out_data;

    // Queue contents as the block should hold them, oldest first
    logic signed [fwrr_pkg::WORD_W-1:0] stored_words[$];
    fwrr_pkg::out_word_t                expected_results[$];
    pending_word_t                      pending_words[$];

    int unsigned words_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned full_refusals   = 0;
    int unsigned empty_refusals  = 0;
    int unsigned deepest         = 0;
    int unsigned error_count     = 0;

    bit          all_results_in = 1'b1;
    int unsigned burst_left     = 0;
    int unsigned gap_left       = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    logic [1:0]  stall_mode     = 2'd0;
    logic [31:0] rx_cycle       = '0;

    fifo_with_rear_removal u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // Apply one command to the queue and work out the result word it gives
    function automatic fwrr_pkg::out_word_t apply_command(fwrr_pkg::in_word_t w);
        fwrr_pkg::out_word_t r;
        r = '0;
        r.status = fwrr_pkg::ST_DONE;
        case (w.cmd)
            fwrr_pkg::CMD_APPEND:
                if (stored_words.size() >= QUEUE_DEPTH)
                begin
                    r.status = fwrr_pkg::ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    stored_words.push_back(w.value);
                end
            fwrr_pkg::CMD_REMOVE_FRONT:
                if (stored_words.size() == 0)
                begin
                    r.status = fwrr_pkg::ST_EMPTY;
                    empty_refusals++;
                end
                else
                begin
                    r.removed_value = stored_words.pop_front();
                end
            fwrr_pkg::CMD_REMOVE_REAR:
                if (stored_words.size() == 0)
                begin
                    r.status = fwrr_pkg::ST_EMPTY;
                    empty_refusals++;
                end
                else
                begin
                    r.removed_value = stored_words.pop_back();
                end
            default:
                stored_words.delete();
        endcase
        r.length = fwrr_pkg::LENGTH_W'(stored_words.size());
        if (stored_words.size() != 0)
        begin
            r.front_value = stored_words[0];
            r.rear_value  = stored_words[$];
        end
        if (stored_words.size() > deepest)
            deepest = stored_words.size();
        return r;
    endfunction

    function automatic logic signed [fwrr_pkg::WORD_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    // Clear is kept rare so that the queue gets the chance to fill
    function automatic fwrr_pkg::cmd_t pick_cmd(int unsigned append_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            return fwrr_pkg::CMD_CLEAR;
        if (r < 3 + append_pct)
            return fwrr_pkg::CMD_APPEND;
        return $urandom_range(1) ? fwrr_pkg::CMD_REMOVE_FRONT : fwrr_pkg::CMD_REMOVE_REAR;
    endfunction

    task automatic queue_word(fwrr_pkg::cmd_t c, logic signed [fwrr_pkg::WORD_W-1:0] v,
                              bit drain);
        pending_word_t p;
        p.word.cmd    = c;
        p.word.value  = v;
        p.drain_first = drain;
        pending_words.push_back(p);
    endtask

    // Sampled away from the active edge so the driver sees a settled count
    always @(negedge clk)
        all_results_in <= (expected_results.size() == 0);

    // Driver: bursts of words with random gaps, holding each word until taken
    always @(posedge clk or negedge rst_n)
    begin
        bit            took;
        pending_word_t p;
        took = 1'b0;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(apply_command(in_data));
                words_accepted++;
                took = 1'b1;
            end
            if (in_valid && !in_ready)
            begin
                // hold the word until the block takes it
            end
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_words.size() != 0 &&
                     (!pending_words[0].drain_first || (!took && all_results_in)))
            begin
                p = pending_words.pop_front();
                in_valid <= 1'b1;
                in_data  <= p.word;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    case ($urandom_range(7))
                        0, 1, 2: gap_left <= 0;
                        7:       gap_left <= $urandom_range(10, 20);
                        default: gap_left <= $urandom_range(1, 5);
                    endcase
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern picked anew each time rx_cycle[5:0] wraps, plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
            stall_mode <= 2'd0;
            rx_cycle   <= '0;
        end
        else
        begin
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && words_accepted >= 250)
            begin
                out_ready <= 1'b0;
                hold_left <= LONG_HOLD - 1;
                hold_done <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    2'd0:    out_ready <= 1'b1;
                    2'd1:    out_ready <= 1'($urandom_range(1));
                    2'd2:    out_ready <= ($urandom_range(3) == 0);
                    default: out_ready <= (rx_cycle[2:0] != 3'd0);
                endcase
            end
            rx_cycle <= rx_cycle + 32'd1;
            if (rx_cycle[5:0] == 6'd63)
                stall_mode <= 2'($urandom_range(3));
        end
    end

    // Monitor: each result word against the oldest expectation
    always @(posedge clk)
    begin
        fwrr_pkg::out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result word with none expected, length",
                                32'(out_data.length), '0);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (out_data.removed_value !== want.removed_value)
                    report_mismatch("removed_value", out_data.removed_value,
                                    want.removed_value);
                if (out_data.status !== want.status)
                    report_mismatch("status", 32'(out_data.status), 32'(want.status));
                if (out_data.length !== want.length)
                    report_mismatch("length", 32'(out_data.length), 32'(want.length));
                if (out_data.front_value !== want.front_value)
                    report_mismatch("front_value", out_data.front_value, want.front_value);
                if (out_data.rear_value !== want.rear_value)
                    report_mismatch("rear_value", out_data.rear_value, want.rear_value);
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int unsigned append_pct;
        // empty queue: removes from both ends are refused, clear is harmless
        queue_word(fwrr_pkg::CMD_REMOVE_FRONT, pick_value(), 1'b0);
        queue_word(fwrr_pkg::CMD_REMOVE_REAR, pick_value(), 1'b0);
        queue_word(fwrr_pkg::CMD_CLEAR, pick_value(), 1'b0);
        // fill to the brim with extreme and patterned words, then overfill, remove from each end and clear
        queue_word(fwrr_pkg::CMD_APPEND, 32'sh7fff_ffff, 1'b0);
        queue_word(fwrr_pkg::CMD_APPEND, 32'sh8000_0000, 1'b0);
        queue_word(fwrr_pkg::CMD_APPEND, '0, 1'b0);
        queue_word(fwrr_pkg::CMD_APPEND, -1, 1'b0);
        queue_word(fwrr_pkg::CMD_APPEND, 1, 1'b0);
        queue_word(fwrr_pkg::CMD_APPEND, 32'sh5555_5555, 1'b0);
        queue_word(fwrr_pkg::CMD_APPEND, 32'shaaaa_aaaa, 1'b0);
        for (int i = 0; i < QUEUE_DEPTH - 7; i++)
            queue_word(fwrr_pkg::CMD_APPEND, $urandom(), 1'b0);
        queue_word(fwrr_pkg::CMD_APPEND, pick_value(), 1'b0);
        queue_word(fwrr_pkg::CMD_REMOVE_FRONT, pick_value(), 1'b0);
        queue_word(fwrr_pkg::CMD_REMOVE_REAR, pick_value(), 1'b0);
        queue_word(fwrr_pkg::CMD_CLEAR, pick_value(), 1'b0);
        // a single word taken from the front empties the queue
        queue_word(fwrr_pkg::CMD_APPEND, pick_value(), 1'b0);
        queue_word(fwrr_pkg::CMD_REMOVE_FRONT, pick_value(), 1'b0);

        // random part in segments that lean towards filling or draining, or are balanced
        append_pct = 50;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       append_pct = 15;
                    1:       append_pct = 50;
                    default: append_pct = 85;
                endcase
            end
            queue_word(pick_cmd(append_pct), pick_value(), (i == 0) || (i == 350));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TIME) @(negedge clk);

        $display("Ran %0d commands, %0d results checked, peak length %0d of %0d",
                 words_accepted, results_checked, deepest, QUEUE_DEPTH);
        $display("Refusals: %0d on a full queue, %0d on an empty one; %0d mismatches",
                 full_refusals, empty_refusals, error_count);
        if (error_count == 0)
            $display("fifo_with_rear_removal_test: done, clean");
        else
            $display("fifo_with_rear_removal_test: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("fifo_with_rear_removal_test: done, errors");
        $finish;
    end

endmodule
